### rtl/core/rpw_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and color helpers for the RGB565 pixel writer.
// No dependencies; every other file imports this package.
package rpw_pkg;

  localparam int MAX_BLOCK_SIDE = 16;
  localparam int ADDR_W         = 16;
  localparam int COLOR_W        = 8;
  localparam int LEFT_W         = 10;
  localparam int COLS_W         = 5;
  localparam int COL_W          = 4;
  localparam int ROW_W          = 5;
  localparam int WIDTH_W        = 11;
  localparam int WORD_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 11;
  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = 1;
  localparam int QCNT_W         = 2;
  localparam int OFS_W          = 3;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd320;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAGNIFY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;

  // one write of the 2x2 block: top-left, top-right, bottom-left, bottom-right
  typedef enum logic [1:0] {
    BEAT_BASE  = 2'd0,
    BEAT_RIGHT = 2'd1,
    BEAT_DOWN  = 2'd2,
    BEAT_DIAG  = 2'd3
  } beat_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               magnify;
  } rpw_entry_t;

  typedef struct packed {
    logic [OFS_W-1:0] red;
    logic [OFS_W-1:0] green;
    logic [OFS_W-1:0] blue;
  } dither_t;

  function automatic dither_t dither_offset(input beat_t beat);
    dither_t d;
    unique case (beat)
      BEAT_BASE:  d = '{red: 3'd0, green: 3'd0, blue: 3'd0};
      BEAT_RIGHT: d = '{red: 3'd4, green: 3'd2, blue: 3'd4};
      BEAT_DOWN:  d = '{red: 3'd6, green: 3'd3, blue: 3'd6};
      BEAT_DIAG:  d = '{red: 3'd2, green: 3'd1, blue: 3'd2};
      default:    d = '{red: 3'd0, green: 3'd0, blue: 3'd0};
    endcase
    return d;
  endfunction

  function automatic logic [COLOR_W-1:0] sat_add(input logic [COLOR_W-1:0] v,
                                                 input logic [OFS_W-1:0] d);
    logic [COLOR_W:0] s;
    s = {1'b0, v} + {{(COLOR_W-OFS_W+1){1'b0}}, d};
    return s[COLOR_W] ? {COLOR_W{1'b1}} : s[COLOR_W-1:0];
  endfunction

  // byte-swapped RGB565
  function automatic logic [WORD_W-1:0] pack565(input logic [COLOR_W-1:0] r,
                                                input logic [COLOR_W-1:0] g,
                                                input logic [COLOR_W-1:0] b);
    return {g[4:2], b[7:3], r[7:3], g[7:5]};
  endfunction

endpackage

### rtl/core/rpw_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: pixel input, buffer write output, config.
// Depends on rpw_pkg for field widths.
interface rpw_pixel_if import rpw_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               block_start;
  logic [LEFT_W-1:0]  block_left;
  logic [COLS_W-1:0]  block_cols;
  modport source (output valid, red, green, blue, block_start, block_left, block_cols,
                  input ready);
  modport sink (input valid, red, green, blue, block_start, block_left, block_cols,
                output ready);
endinterface

interface rpw_write_if import rpw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] write_address;
  logic [WORD_W-1:0] pixel_word;
  logic              last_write;
  modport source (output valid, write_address, pixel_word, last_write, input ready);
  modport sink (input valid, write_address, pixel_word, last_write, output ready);
endinterface

interface rpw_cfg_if import rpw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

### rtl/core/rgb565_pixel_writer_2x_dither.sv
`timescale 1ns / 1ps
// Top level of the RGB565 pixel writer with 2x upscale and dither.
// Depends on rpw_pkg, rpw_ifs, rpw_front, rpw_queue, rpw_back.
//
//   channel  role    payload
//   pix      sink    red, green, blue, block_start, block_left, block_cols
//   wr       source  write_address, pixel_word, last_write
//   cfg      sink    reg_index, data (0 magnify_mode, 1 image_width)
//
// Normal mode: one pixel per cycle while wr is ready; magnify mode: four
// buffer writes per pixel, one per cycle on wr while wr is ready.
// A pixel's first write passes through the queue and the wr output
// register before it is presented on wr; a stalled wr can hold it back.
// A two-entry queue lets the front take pixels while the write port stalls.
// rst is synchronous; pix and cfg are ready once reset is released.
module rgb565_pixel_writer_2x_dither import rpw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  rpw_pixel_if.sink   pix,
  rpw_write_if.source wr,
  rpw_cfg_if.sink     cfg
);

  logic               push, pop, full, empty;
  rpw_entry_t         push_data, head;
  logic               magnify_mode;
  logic [WIDTH_W-1:0] image_width;

  rpw_front u_front (
    .clk          (clk),
    .rst          (rst),
    .pix          (pix),
    .cfg          (cfg),
    .queue_full   (full),
    .push         (push),
    .push_data    (push_data),
    .magnify_mode (magnify_mode),
    .image_width  (image_width)
  );

  rpw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  rpw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .empty       (empty),
    .pop         (pop),
    .image_width (image_width),
    .wr          (wr)
  );

`ifndef SYNTHESIS
  a_mode_stable_busy: assert property (@(posedge clk) disable iff (rst)
    !empty |-> head.magnify == magnify_mode)
    else $error("magnify mode changed with pixels in flight");
`endif

endmodule

### rtl/core/rpw_front.sv
`timescale 1ns / 1ps
// Front end: config registers, block column/row tracking, base address.
// Depends on rpw_pkg and rpw_ifs.
module rpw_front import rpw_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  rpw_pixel_if.sink           pix,
  rpw_cfg_if.sink             cfg,
  input  logic                queue_full,
  output logic                push,
  output rpw_entry_t          push_data,
  output logic                magnify_mode,
  output logic [WIDTH_W-1:0]  image_width
);

  logic [COL_W-1:0]  column_count, column_count_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic [LEFT_W-1:0] latched_left;
  logic [COLS_W-1:0] latched_cols;

  logic [COLS_W-1:0]  cols_clamped, cols_eff;
  logic [LEFT_W-1:0]  left_eff;
  logic [COL_W-1:0]   col_eff;
  logic [ROW_W-1:0]   row_eff;
  logic [COLS_W-1:0]  col_inc;
  logic [LEFT_W:0]    left_col;
  logic [ADDR_W-1:0]  row_off;
  logic [ADDR_W-1:0]  addr;

  assign cfg.ready = 1'b1;
  assign pix.ready = !queue_full;
  assign push      = pix.valid && !queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnify_mode <= 1'b0;
      image_width  <= WIDTH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_MAGNIFY:     magnify_mode <= cfg.data[0];
        REG_IMAGE_WIDTH: image_width  <= cfg.data[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pix.block_cols == '0)
      cols_clamped = COLS_W'(1);
    else if (pix.block_cols > COLS_W'(MAX_BLOCK_SIDE))
      cols_clamped = COLS_W'(MAX_BLOCK_SIDE);
    else
      cols_clamped = pix.block_cols;

    // a start pixel is column 0 of row 0 of the new rectangle
    cols_eff = pix.block_start ? cols_clamped    : latched_cols;
    left_eff = pix.block_start ? pix.block_left  : latched_left;
    col_eff  = pix.block_start ? '0              : column_count;
    row_eff  = pix.block_start ? '0              : row_count;

    left_col = {1'b0, left_eff} + {{(LEFT_W-COL_W+1){1'b0}}, col_eff};
    row_off  = ADDR_W'({{(ADDR_W-WIDTH_W){1'b0}}, image_width} *
                       {{(ADDR_W-ROW_W){1'b0}}, row_eff});
    if (magnify_mode)
      addr = ADDR_W'({left_col, 1'b0}) + {row_off[ADDR_W-3:0], 2'b00};
    else
      addr = ADDR_W'(left_col) + row_off;

    col_inc = {1'b0, col_eff} + COLS_W'(1);
    if (col_inc >= cols_eff) begin
      column_count_next = '0;
      row_count_next    = row_eff + ROW_W'(1);
    end else begin
      column_count_next = col_inc[COL_W-1:0];
      row_count_next    = row_eff;
    end

    push_data.addr    = addr;
    push_data.red     = pix.red;
    push_data.green   = pix.green;
    push_data.blue    = pix.blue;
    push_data.magnify = magnify_mode;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      latched_left <= '0;
      latched_cols <= COLS_W'(1);
    end else if (push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      latched_left <= left_eff;
      latched_cols <= cols_eff;
    end
  end

`ifndef SYNTHESIS
  a_cols_range: assert property (@(posedge clk) disable iff (rst)
    latched_cols != '0 && latched_cols <= COLS_W'(MAX_BLOCK_SIDE))
    else $error("latched block width out of range");
  a_col_below_width: assert property (@(posedge clk) disable iff (rst)
    {1'b0, column_count} < latched_cols)
    else $error("column counter reached block width");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    queue_full |-> !push)
    else $error("pixel pushed into full queue");
`endif

endmodule

### rtl/core/rpw_queue.sv
`timescale 1ns / 1ps
// Small flop-based FIFO between the front end and the write sequencer.
// Depends on rpw_pkg.
module rpw_queue import rpw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rpw_entry_t push_data,
  output logic       full,
  input  logic       pop,
  output rpw_entry_t head,
  output logic       empty
);

  rpw_entry_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = count == QCNT_W'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");
  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count == '0 || count == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr == rd_ptr)
    else $error("queue pointers disagree with count");
`endif

endmodule

### rtl/core/rpw_back.sv
`timescale 1ns / 1ps
// Back end: walks the 1 or 4 buffer writes of each queued pixel, applies
// dither offsets and RGB565 packing into the output register. Depends on rpw_pkg.
module rpw_back import rpw_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  rpw_entry_t         head,
  input  logic               empty,
  output logic               pop,
  input  logic [WIDTH_W-1:0] image_width,
  rpw_write_if.source        wr
);

  beat_t             beat, beat_next;
  logic              load;
  logic              last_beat;
  dither_t           ofs;
  logic [ADDR_W-1:0] stride;
  logic [ADDR_W-1:0] addr;
  logic [WORD_W-1:0] word;

  assign load      = !empty && (!wr.valid || wr.ready);
  assign last_beat = !head.magnify || beat == BEAT_DIAG;
  assign pop       = load && last_beat;

  always_comb begin
    unique case (beat)
      BEAT_BASE:  beat_next = BEAT_RIGHT;
      BEAT_RIGHT: beat_next = BEAT_DOWN;
      BEAT_DOWN:  beat_next = BEAT_DIAG;
      BEAT_DIAG:  beat_next = BEAT_BASE;
      default:    beat_next = BEAT_BASE;
    endcase
    if (last_beat) beat_next = BEAT_BASE;
  end

  always_comb begin
    ofs    = dither_offset(beat);
    stride = {{(ADDR_W-WIDTH_W-1){1'b0}}, image_width, 1'b0};
    addr   = head.addr;
    if (beat == BEAT_DOWN || beat == BEAT_DIAG)  addr = addr + stride;
    if (beat == BEAT_RIGHT || beat == BEAT_DIAG) addr = addr + ADDR_W'(1);
    word = pack565(sat_add(head.red, ofs.red), sat_add(head.green, ofs.green),
                   sat_add(head.blue, ofs.blue));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat     <= BEAT_BASE;
      wr.valid <= 1'b0;
    end else begin
      if (load) begin
        beat     <= beat_next;
        wr.valid <= 1'b1;
      end else if (wr.ready) begin
        wr.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      wr.write_address <= addr;
      wr.pixel_word    <= word;
      wr.last_write    <= last_beat;
    end
  end

`ifndef SYNTHESIS
  a_mid_block_has_entry: assert property (@(posedge clk) disable iff (rst)
    beat != BEAT_BASE |-> !empty && head.magnify)
    else $error("mid-block beat without a magnified pixel at the head");
  a_pop_on_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> wr.valid && wr.last_write)
    else $error("pixel retired without its final write");
  a_plain_single: assert property (@(posedge clk) disable iff (rst)
    load && !head.magnify |-> pop)
    else $error("plain pixel did not retire on its only write");
`endif

endmodule

### dv/rgb565_pixel_writer_2x_dither_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the RGB565 pixel writer: directed and random pixel
// traffic in both modes, with a scoreboard that predicts every strip-buffer write.
// Depends on rpw_pkg, rpw_ifs and the rgb565_pixel_writer_2x_dither RTL.
module rgb565_pixel_writer_2x_dither_tb;
  import rpw_pkg::*;

  localparam int PERIOD_HALF = 10;
  localparam int LONG_HOLD   = 100;
  localparam int QUIET_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  // indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

  typedef struct {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               block_start;
    logic [LEFT_W-1:0]  block_left;
    logic [COLS_W-1:0]  block_cols;
  } pixel_item_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
    logic              last;
  } buffer_write_t;

  class write_scoreboard;
    buffer_write_t      pending_writes[$];
    int unsigned        pixels_seen;
    int unsigned        writes_checked;
    int unsigned        mismatches;
    logic               magnify;
    logic [WIDTH_W-1:0] stride_px;
    logic [LEFT_W-1:0]  blk_left;
    logic [COLS_W-1:0]  blk_cols;
    logic [COL_W-1:0]   col_idx;
    logic [ROW_W-1:0]   row_idx;

    function new();
      magnify   = 1'b0;
      stride_px = WIDTH_RESET;
      blk_left  = '0;
      blk_cols  = COLS_W'(1);
      col_idx   = '0;
      row_idx   = '0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MAGNIFY:     magnify = data[0];
        REG_IMAGE_WIDTH: stride_px = data;
        default: ;
      endcase
    endfunction

    function logic [COLOR_W-1:0] clip_add(logic [COLOR_W-1:0] v, int unsigned d);
      int unsigned s;
      s = v + d;
      return (s > 255) ? {COLOR_W{1'b1}} : COLOR_W'(s);
    endfunction

    // byte-swapped 565: low byte R5:G3hi, high byte G3lo:B5
    function logic [WORD_W-1:0] tint(pixel_item_t p, int unsigned dr, int unsigned dg,
                                     int unsigned db);
      logic [COLOR_W-1:0] r, g, b;
      logic [WORD_W-1:0]  w;
      r = clip_add(p.red, dr);
      g = clip_add(p.green, dg);
      b = clip_add(p.blue, db);
      w[2:0]   = g[7:5];
      w[7:3]   = r[7:3];
      w[12:8]  = b[7:3];
      w[15:13] = g[4:2];
      return w;
    endfunction

    function void expect_write(int unsigned a, logic [WORD_W-1:0] w, logic last);
      buffer_write_t e;
      e.addr = ADDR_W'(a);
      e.word = w;
      e.last = last;
      pending_writes.push_back(e);
    endfunction

    function void note_pixel(pixel_item_t p);
      int unsigned cols, a, base, stride, next_col;
      pixels_seen++;
      if (p.block_start) begin
        cols = p.block_cols;
        if (cols == 0) cols = 1;
        if (cols > MAX_BLOCK_SIDE) cols = MAX_BLOCK_SIDE;
        blk_left = p.block_left;
        blk_cols = COLS_W'(cols);
        col_idx  = '0;
        row_idx  = '0;
      end
      if (!magnify) begin
        a = blk_left + col_idx + stride_px * row_idx;
        expect_write(a, tint(p, 0, 0, 0), 1'b1);
      end else begin
        stride = 2 * stride_px;
        base   = 2 * (blk_left + col_idx) + 2 * stride * row_idx;
        expect_write(base,              tint(p, 0, 0, 0), 1'b0);
        expect_write(base + 1,          tint(p, 4, 2, 4), 1'b0);
        expect_write(base + stride,     tint(p, 6, 3, 6), 1'b0);
        expect_write(base + stride + 1, tint(p, 2, 1, 2), 1'b1);
      end
      next_col = col_idx + 1;
      if (next_col >= blk_cols) begin
        col_idx = '0;
        row_idx = row_idx + 1'b1;
      end else begin
        col_idx = COL_W'(next_col);
      end
    endfunction

    function void check_write(logic [ADDR_W-1:0] a, logic [WORD_W-1:0] w, logic last);
      buffer_write_t e;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        report($sformatf("unexpected write addr %h word %h last %b", a, w, last));
        return;
      end
      e = pending_writes.pop_front();
      if (e.addr !== a || e.word !== w || e.last !== last)
        report($sformatf("write %0d: expected addr %h word %h last %b, got addr %h word %h last %b",
                         writes_checked, e.addr, e.word, e.last, a, w, last));
    endfunction

    function void close_out();
      if (pending_writes.size() != 0) begin
        report($sformatf("%0d expected writes never arrived, first addr %h",
                         pending_writes.size(), pending_writes[0].addr));
        mismatches += pending_writes.size() - 1;
      end
    endfunction

    function int unsigned pending();
      return pending_writes.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  rpw_pixel_if pix ();
  rpw_write_if wr ();
  rpw_cfg_if   cfg ();

  rgb565_pixel_writer_2x_dither uut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .wr  (wr),
    .cfg (cfg)
  );

  write_scoreboard sb;
  bit          idle_on     = 1'b0;
  bit          hold_writes = 1'b0;
  bit          hold_done   = 1'b0;
  int          stall_left  = 0;
  int          quiet_cycles = 0;
  int unsigned reg_writes  = 0;

  always begin
    #PERIOD_HALF clk = 1'b1;
    #PERIOD_HALF clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    if (!idle_on) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 12) return 0;
    if (roll < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [COLOR_W-1:0] rand_color();
    // lean toward the top of the range so the dither offsets saturate
    if ($urandom_range(0, 7) == 0) return COLOR_W'($urandom_range(248, 255));
    return COLOR_W'($urandom_range(0, 255));
  endfunction

  function automatic pixel_item_t pixel_of(logic [COLOR_W-1:0] r, logic [COLOR_W-1:0] g,
                                           logic [COLOR_W-1:0] b, logic start,
                                           logic [LEFT_W-1:0] left, logic [COLS_W-1:0] cols);
    pixel_item_t p;
    p.red         = r;
    p.green       = g;
    p.blue        = b;
    p.block_start = start;
    p.block_left  = left;
    p.block_cols  = cols;
    return p;
  endfunction

  task automatic drive_pixel(input pixel_item_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid       <= 1'b1;
    pix.red         <= p.red;
    pix.green       <= p.green;
    pix.blue        <= p.blue;
    pix.block_start <= p.block_start;
    pix.block_left  <= p.block_left;
    pix.block_cols  <= p.block_cols;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    sb.note_pixel(p);
  endtask

  // leaves cfg.valid high; the caller drops it after its last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.data      <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    sb.set_register(idx, data);
    reg_writes++;
  endtask

  task automatic wait_idle();
    pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic set_mode(input logic [CFG_DATA_W-1:0] mag_word,
                          input logic [CFG_DATA_W-1:0] stride);
    wait_idle();
    write_reg(REG_MAGNIFY, mag_word);
    write_reg(REG_IMAGE_WIDTH, stride);
    cfg.valid <= 1'b0;
  endtask

  // mostly complete blocks with random content, some truncated or with stray starts
  task automatic run_random(input int n_items, input bit long_block);
    int sent, eff, len, k;
    bit well_formed;
    logic [COLS_W-1:0] cols;
    logic [LEFT_W-1:0] left;
    sent = 0;
    while (sent < n_items) begin
      idle_on     = ($urandom_range(0, 3) != 0);
      left        = LEFT_W'($urandom_range(0, 1023));
      well_formed = ($urandom_range(0, 4) != 0);
      if (long_block) begin
        // one column, enough rows to wrap the row counter
        cols        = COLS_W'(1);
        len         = 34;
        well_formed = 1'b1;
        long_block  = 1'b0;
      end else begin
        case ($urandom_range(0, 9))
          0: cols = '0;
          1: cols = COLS_W'($urandom_range(17, 31));
          default: cols = COLS_W'($urandom_range(1, 16));
        endcase
        eff = (cols == 0) ? 1 : ((cols > MAX_BLOCK_SIDE) ? MAX_BLOCK_SIDE : cols);
        len = well_formed ? eff * $urandom_range(1, 3) : $urandom_range(1, 2 * eff);
      end
      for (k = 0; k < len && sent < n_items; k++) begin
        drive_pixel(pixel_of(rand_color(), rand_color(), rand_color(),
                             well_formed ? (k == 0) : ($urandom_range(0, 3) == 0),
                             (k == 0) ? left : LEFT_W'($urandom_range(0, 1023)),
                             (k == 0) ? cols : COLS_W'($urandom_range(0, 31))));
        sent++;
      end
    end
  endtask

  // write side: check each transaction, then decide ready for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      wr.ready <= 1'b0;
    end else begin
      if (wr.valid && wr.ready) sb.check_write(wr.write_address, wr.pixel_word, wr.last_write);
      if (hold_writes && !hold_done) begin
        hold_done  = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        wr.ready <= 1'b0;
      end else begin
        wr.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (pix.valid && pix.ready) || (wr.valid && wr.ready) || (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", quiet_cycles);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sb = new();
    pix.valid       <= 1'b0;
    pix.red         <= '0;
    pix.green       <= '0;
    pix.blue        <= '0;
    pix.block_start <= 1'b0;
    pix.block_left  <= '0;
    pix.block_cols  <= '0;
    cfg.valid       <= 1'b0;
    cfg.reg_index   <= '0;
    cfg.data        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // normal mode at reset settings; first two pixels arrive before any start
    drive_pixel(pixel_of(8'h00, 8'h00, 8'h00, 1'b0, 10'h3FF, 5'd31));
    drive_pixel(pixel_of(8'hFF, 8'hFF, 8'hFF, 1'b0, 10'h000, 5'd0));
    drive_pixel(pixel_of(8'hFF, 8'h00, 8'hFF, 1'b1, 10'd1023, 5'd0));
    drive_pixel(pixel_of(8'h00, 8'hFF, 8'h00, 1'b0, 10'd0, 5'd0));
    drive_pixel(pixel_of(8'h1C, 8'hE0, 8'hF8, 1'b1, 10'd0, 5'd31));
    drive_pixel(pixel_of(8'hE0, 8'h1C, 8'h07, 1'b0, 10'd0, 5'd0));
    drive_pixel(pixel_of(8'h07, 8'h03, 8'hE0, 1'b0, 10'd0, 5'd0));
    drive_pixel(pixel_of(8'h80, 8'h80, 8'h80, 1'b1, 10'd5, 5'd17));
    drive_pixel(pixel_of(8'h7F, 8'h7F, 8'h7F, 1'b1, 10'd1000, 5'd16));

    // magnify with a stride of 1024; spare indexes must be ignored
    wait_idle();
    write_reg(REG_UNUSED_A, 11'h7FF);
    write_reg(REG_MAGNIFY, 11'h7FF);
    write_reg(REG_UNUSED_B, 11'h000);
    write_reg(REG_IMAGE_WIDTH, 11'd1024);
    cfg.valid <= 1'b0;
    drive_pixel(pixel_of(8'hFF, 8'hFF, 8'hFF, 1'b1, 10'd1023, 5'd16));
    drive_pixel(pixel_of(8'hFA, 8'hFD, 8'hFA, 1'b0, 10'd0, 5'd0));
    drive_pixel(pixel_of(8'h00, 8'h00, 8'h00, 1'b0, 10'd0, 5'd0));
    drive_pixel(pixel_of(8'hF9, 8'hFC, 8'hFB, 1'b1, 10'd1023, 5'd1));
    drive_pixel(pixel_of(8'h05, 8'h1E, 8'hFE, 1'b0, 10'd0, 5'd0));
    drive_pixel(pixel_of(8'hFE, 8'hFE, 8'hFD, 1'b0, 10'd0, 5'd0));

    // zero stride collapses all rows onto row 0
    set_mode(11'h001, 11'd0);
    drive_pixel(pixel_of(8'h40, 8'hC0, 8'h20, 1'b1, 10'd512, 5'd2));
    drive_pixel(pixel_of(8'hFC, 8'hFE, 8'hFC, 1'b0, 10'd0, 5'd0));
    drive_pixel(pixel_of(8'h12, 8'h34, 8'h56, 1'b0, 10'd0, 5'd0));

    set_mode(11'h002, 11'd1);
    run_random(34, 1'b1);
    set_mode(11'h001, 11'd2047);
    hold_writes = 1'b1;
    run_random(34, 1'b1);
    set_mode(11'h000, 11'd0);
    run_random(24, 1'b0);
    set_mode(11'h001, 11'd320);
    run_random(24, 1'b0);
    set_mode(11'h000, 11'd1024);
    run_random(24, 1'b0);
    set_mode(11'h001, 11'd1);
    run_random(24, 1'b0);
    set_mode(11'h000, CFG_DATA_W'($urandom_range(1, 2047)));
    run_random(24, 1'b0);
    set_mode(11'h001, CFG_DATA_W'($urandom_range(1, 2047)));
    run_random(24, 1'b0);
    set_mode(11'h001, 11'd0);
    run_random(14, 1'b0);

    wait_idle();
    repeat (4) @(posedge clk);
    sb.close_out();
    $display("Run covered %0d pixels, %0d buffer writes and %0d register writes,",
             sb.pixels_seen, sb.writes_checked, reg_writes);
    $display("both modes, strides 0 to 2047, clamped block widths and row wrap.");
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rpw_pkg.sv
rtl/core/rpw_ifs.sv
rtl/core/rpw_front.sv
rtl/core/rpw_queue.sv
rtl/core/rpw_back.sv
rtl/core/rgb565_pixel_writer_2x_dither.sv
dv/rgb565_pixel_writer_2x_dither_tb.sv
